@@ design/cps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants
// Message kinds, protocol modes, register indexes and the structs that carry
// the process state and the per-item emission plan.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_PROPOSE = 3'd1;
    localparam logic [2:0] K_ECHO    = 3'd2;
    localparam logic [2:0] K_ACK     = 3'd3;
    localparam logic [2:0] K_DECIDE  = 3'd4;
    localparam logic [2:0] K_VOTE    = 3'd5;
    localparam logic [2:0] K_KING    = 3'd6;
    localparam logic [2:0] K_COMMIT  = 3'd7;

    localparam logic [2:0] M_FLOOD    = 3'd0;
    localparam logic [2:0] M_KING     = 3'd1;
    localparam logic [2:0] M_ECHO     = 3'd2;
    localparam logic [2:0] M_ROTATE   = 3'd3;
    localparam logic [2:0] M_MAJORITY = 3'd4;
    localparam logic [2:0] M_TWOPHASE = 3'd5;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd1;
    localparam logic [2:0] REG_FAULT   = 3'd2;
    localparam logic [2:0] REG_OWN_ID  = 3'd3;
    localparam logic [2:0] REG_INPUT   = 3'd4;
    localparam logic [2:0] REG_CORRECT = 3'd5;

    localparam logic [1:0] VAL_BIT0 = 2'd1;  // (1 << 0)
    localparam logic [1:0] VAL_BIT1 = 2'd2;  // (1 << 1)

    typedef struct packed {
        logic [2:0] protocol_mode;
        logic [3:0] fault_bound;
        logic [3:0] own_id;
        logic       own_input;
        logic       is_correct;
    } cps_cfg_t;

    typedef struct packed {
        logic       started;
        logic [1:0] proposal_value;
        logic [7:0] phase_number;
        logic [7:0] zero_votes;
        logic [7:0] one_votes;
        logic [1:0] known_values;
        logic [7:0] round_number;
        logic       decided_flag;
        logic [1:0] decided_value;
    } cps_state_t;

    // Emission plan: zero, one or two broadcasts, or one single message.
    typedef struct packed {
        logic [1:0] nb;
        logic [2:0] kind1;
        logic [2:0] kind2;
        logic [1:0] value;
        logic [7:0] rnd;
        logic       single;
        logic [3:0] sdest;
        logic       dnow;
        logic [1:0] dval;
    } cps_plan_t;

endpackage

@@ design/cps_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_mod: iterative remainder unit
// Restoring division producing dividend mod divisor, one quotient bit per
// cycle. The divisor is at most 16, so the remainder fits in five bits.
// ----------------------------------------------------------------------------
module cps_mod (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [4:0] divisor,
    output logic       done,
    output logic [4:0] remainder
);
    import cps_pkg::*;

    localparam int DW = 8;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [4:0]    rem_reg, rem_next;
    logic [4:0]    dsr_reg, dsr_next;
    logic          done_reg, done_next;
    logic [4:0]    trial;

    assign trial = {rem_reg[3:0], dvd_reg[DW-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(DW);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = (trial >= dsr_reg) ? (trial - dsr_reg) : trial;
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/cps_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_step: protocol step logic
// Given the stored state, one input item and the remainder from the shared
// unit, computes the next state and the plan of outgoing messages.
// ----------------------------------------------------------------------------
module cps_step (
    input  cps_pkg::cps_cfg_t   cfg,
    input  logic [4:0]          n_eff,
    input  cps_pkg::cps_state_t st,
    input  logic [2:0]          func,
    input  logic [1:0]          msg_value,
    input  logic [7:0]          msg_round,
    input  logic [3:0]          msg_sender,
    input  logic [4:0]          mod_rem,
    output cps_pkg::cps_state_t nxt,
    output cps_pkg::cps_plan_t  plan
);
    import cps_pkg::*;

    logic       first;
    logic [3:0] f_eff;
    logic [4:0] half;
    logic [5:0] king_thr;
    logic [7:0] z1, o1;
    logic [8:0] vsum;
    logic [7:0] next_ph;
    logic       is_lead;
    logic [1:0] mask;
    logic [1:0] d;
    logic [1:0] own_v;

    assign first    = !st.started;
    assign f_eff    = (cfg.fault_bound == 4'd0) ? 4'd1 : cfg.fault_bound;
    assign half     = {1'b0, n_eff[4:1]};
    assign king_thr = {1'b0, half} + {2'b0, f_eff};
    assign own_v    = {1'b0, cfg.own_input};
    assign is_lead  = ({1'b0, cfg.own_id} == mod_rem);
    assign next_ph  = (st.phase_number == 8'hFF) ? 8'hFF : st.phase_number + 8'd1;
    assign mask     = st.known_values | msg_value;
    // Vote counters after counting this message's value; saturate at 255.
    assign z1 = (msg_value == 2'd0 && st.zero_votes != 8'hFF) ?
                st.zero_votes + 8'd1 : st.zero_votes;
    assign o1 = (msg_value != 2'd0 && st.one_votes != 8'hFF) ?
                st.one_votes + 8'd1 : st.one_votes;
    assign vsum = {1'b0, z1} + {1'b0, o1};
    assign d    = (z1 >= o1) ? 2'd0 : 2'd1;

    always_comb
    begin
        nxt  = st;
        plan = '0;
        if (cfg.is_correct && cfg.protocol_mode <= M_TWOPHASE)
        begin
            nxt.started = 1'b1;
            case (cfg.protocol_mode)
                M_FLOOD:
                begin
                    if (first)
                    begin
                        nxt.known_values = cfg.own_input ? VAL_BIT1 : VAL_BIT0;
                        nxt.round_number = 8'd0;
                        plan.nb    = 2'd1;
                        plan.kind1 = K_PROPOSE;
                        plan.value = cfg.own_input ? VAL_BIT1 : VAL_BIT0;
                    end
                    else if (func == K_PROPOSE)
                    begin
                        nxt.known_values = mask;
                        if (msg_round < {4'd0, f_eff})
                        begin
                            nxt.round_number = msg_round + 8'd1;
                            plan.nb    = 2'd1;
                            plan.kind1 = K_PROPOSE;
                            plan.value = mask;
                            plan.rnd   = msg_round + 8'd1;
                        end
                        else
                        begin
                            plan.dnow = 1'b1;
                            plan.dval = (mask == VAL_BIT1) ? 2'd1 : 2'd0;
                        end
                    end
                end
                M_KING:
                begin
                    if (first)
                    begin
                        nxt.proposal_value = own_v;
                        nxt.phase_number   = 8'd1;
                        plan.nb    = 2'd1;
                        plan.kind1 = K_VOTE;
                        plan.value = own_v;
                        plan.rnd   = 8'd1;
                    end
                    else if (func == K_VOTE)
                    begin
                        nxt.zero_votes = z1;
                        nxt.one_votes  = o1;
                        if (z1 > o1)
                            nxt.proposal_value = 2'd0;
                        if (o1 > z1)
                            nxt.proposal_value = 2'd1;
                    end
                    else if (func == K_KING)
                    begin
                        if (!({1'b0, st.zero_votes} >= {3'd0, king_thr} ||
                              {1'b0, st.one_votes} >= {3'd0, king_thr}))
                            nxt.proposal_value = msg_value;
                        nxt.phase_number = next_ph;
                        nxt.zero_votes   = 8'd0;
                        nxt.one_votes    = 8'd0;
                        if (next_ph > {3'd0, f_eff} + 8'd1)
                        begin
                            plan.dnow = 1'b1;
                            plan.dval = nxt.proposal_value;
                        end
                        else
                        begin
                            plan.nb    = is_lead ? 2'd2 : 2'd1;
                            plan.kind1 = K_VOTE;
                            plan.kind2 = K_KING;
                            plan.value = nxt.proposal_value;
                            plan.rnd   = next_ph;
                        end
                    end
                end
                M_ECHO:
                begin
                    if (cfg.own_id == 4'd0 && first)
                    begin
                        plan.nb    = 2'd1;
                        plan.kind1 = K_PROPOSE;
                        plan.value = own_v;
                    end
                    else if (func == K_PROPOSE)
                    begin
                        nxt.proposal_value = msg_value;
                        plan.nb    = 2'd1;
                        plan.kind1 = K_ECHO;
                        plan.value = msg_value;
                    end
                    else if (func == K_ECHO)
                    begin
                        nxt.zero_votes = z1;
                        nxt.one_votes  = o1;
                        if (!st.decided_flag)
                        begin
                            // Count reaches n - f; a threshold at or below zero
                            // is met by any count.
                            if ({1'b0, z1} + {5'd0, f_eff} >= {4'd0, n_eff})
                            begin
                                plan.dnow = 1'b1;
                                plan.dval = 2'd0;
                            end
                            else if ({1'b0, o1} + {5'd0, f_eff} >= {4'd0, n_eff})
                            begin
                                plan.dnow = 1'b1;
                                plan.dval = 2'd1;
                            end
                        end
                    end
                end
                M_ROTATE:
                begin
                    if (is_lead && (first || func == K_KING))
                    begin
                        nxt.proposal_value = (st.proposal_value != 2'd0) ?
                            st.proposal_value : 2'd1;
                        plan.nb    = 2'd1;
                        plan.kind1 = K_PROPOSE;
                        plan.value = nxt.proposal_value;
                        plan.rnd   = st.round_number;
                    end
                    else if (func == K_PROPOSE)
                    begin
                        nxt.proposal_value = msg_value;
                        nxt.phase_number   = {6'd0, msg_value};
                        plan.single = 1'b1;
                        plan.sdest  = msg_sender;
                        plan.kind1  = K_ACK;
                        plan.value  = msg_value;
                        plan.rnd    = msg_round;
                    end
                    else if (func == K_ACK && is_lead)
                    begin
                        nxt.zero_votes = z1;
                        nxt.one_votes  = o1;
                        if (vsum >= {4'd0, half} + 9'd1 && !st.decided_flag)
                        begin
                            plan.dnow  = 1'b1;
                            plan.dval  = d;
                            plan.nb    = 2'd1;
                            plan.kind1 = K_DECIDE;
                            plan.value = d;
                            plan.rnd   = st.round_number;
                        end
                    end
                    else if (func == K_DECIDE)
                    begin
                        plan.dnow = 1'b1;
                        plan.dval = msg_value;
                    end
                end
                M_MAJORITY:
                begin
                    if (first)
                    begin
                        plan.nb    = 2'd1;
                        plan.kind1 = K_VOTE;
                        plan.value = own_v;
                        if (cfg.own_input)
                            nxt.one_votes = 8'd1;
                        else
                            nxt.zero_votes = 8'd1;
                    end
                    else if (func == K_VOTE)
                    begin
                        nxt.zero_votes = z1;
                        nxt.one_votes  = o1;
                        if (!st.decided_flag && vsum >= {4'd0, half} + 9'd1)
                        begin
                            plan.dnow = 1'b1;
                            plan.dval = d;
                        end
                    end
                end
                default:
                begin
                    if (cfg.own_id == 4'd0 && first)
                    begin
                        plan.nb    = 2'd1;
                        plan.kind1 = K_VOTE;
                        plan.value = own_v;
                        plan.rnd   = 8'd1;
                        nxt.phase_number = 8'd1;
                        if (cfg.own_input)
                            nxt.one_votes = 8'd1;
                        else
                            nxt.zero_votes = 8'd1;
                    end
                    else if (func == K_VOTE && msg_round == 8'd1 && cfg.own_id != 4'd0)
                    begin
                        plan.single = 1'b1;
                        plan.sdest  = 4'd0;
                        plan.kind1  = K_ACK;
                        plan.value  = own_v;
                        plan.rnd    = 8'd1;
                    end
                    else if (func == K_ACK && msg_round == 8'd1 && cfg.own_id == 4'd0)
                    begin
                        nxt.zero_votes = z1;
                        nxt.one_votes  = o1;
                        if (vsum >= {4'd0, n_eff})
                        begin
                            plan.nb    = 2'd1;
                            plan.kind1 = K_COMMIT;
                            plan.value = d;
                            plan.rnd   = 8'd2;
                            plan.dnow  = 1'b1;
                            plan.dval  = d;
                            nxt.phase_number = 8'd2;
                        end
                    end
                    else if (func == K_COMMIT && msg_round == 8'd2 && cfg.own_id != 4'd0)
                    begin
                        plan.dnow = 1'b1;
                        plan.dval = msg_value;
                    end
                end
            endcase
            if (plan.dnow)
            begin
                nxt.decided_flag  = 1'b1;
                nxt.decided_value = plan.dval;
            end
        end
    end

endmodule

@@ design/consensus_process_step_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consensus_process_step_top: one process of a crash-fault consensus protocol
// Runs one of six protocols selected by a register and emits the run of
// outgoing messages caused by each delivered item.
// ----------------------------------------------------------------------------
// Each accepted input transfer is either the first activation of the process
// or one delivered message. The block takes one item at a time: after the
// transfer it runs the eight restoring steps of the shared remainder unit and
// commits the new state, then sends its results one per cycle while the
// output accepts them, one for every other process per broadcast (at most two
// broadcasts, so up to 30 results), or a single message, or one empty result.
// A broadcast slot for this process's own id is skipped and sends nothing;
// output backpressure stalls the results. The final result of each run
// carries tlast. Registers are to be written through the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module consensus_process_step_top #(
    parameter int MAX_PROCS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream; tdata: func[2:0], msg_value[4:3], msg_round[12:5],
    // msg_sender[16:13], zero fill above
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // Result stream; tdata: send_valid[0], dest_id[4:1], out_kind[7:5],
    // out_value[9:8], out_round[17:10], decided_now[18], decision_out[20:19],
    // zero fill above; tlast is last_of_run
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import cps_pkg::*;

    localparam int PROC_LIMIT = (MAX_PROCS < 16) ? MAX_PROCS : 16;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    cps_cfg_t   cfg_reg, cfg_next;
    logic [4:0] count_reg, count_next;
    cps_state_t st_reg, st_next;
    cps_state_t st_calc;
    cps_plan_t  plan_reg, plan_next, plan_calc;
    logic [23:0] in_reg, in_next;
    logic [4:0] idx_reg, idx_next;
    logic       bsel_reg, bsel_next;
    logic       mv_reg, mv_next;
    logic [20:0] md_reg, md_next;
    logic       ml_reg, ml_next;

    logic       wr_en;
    logic [4:0] n_eff;
    logic       mod_start, mod_done;
    logic [4:0] mod_rem;
    logic [7:0] mod_dvd;
    logic       slot_free;
    logic       bc_end;

    // Configuration port: always ready, writes in the access phase.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next   = cfg_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                REG_MODE:    cfg_next.protocol_mode = pwdata[2:0];
                REG_COUNT:   count_next             = pwdata[4:0];
                REG_FAULT:   cfg_next.fault_bound   = pwdata[3:0];
                REG_OWN_ID:  cfg_next.own_id        = pwdata[3:0];
                REG_INPUT:   cfg_next.own_input     = pwdata[0];
                REG_CORRECT: cfg_next.is_correct    = pwdata[0];
                default:     cfg_next               = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MODE:    prdata = {29'd0, cfg_reg.protocol_mode};
            REG_COUNT:   prdata = {27'd0, count_reg};
            REG_FAULT:   prdata = {28'd0, cfg_reg.fault_bound};
            REG_OWN_ID:  prdata = {28'd0, cfg_reg.own_id};
            REG_INPUT:   prdata = {31'd0, cfg_reg.own_input};
            REG_CORRECT: prdata = {31'd0, cfg_reg.is_correct};
            default:     prdata = 32'd0;
        endcase
    end

    // Process count clamped to 2..min(MAX_PROCS, 16).
    assign n_eff = (count_reg < 5'd2) ? 5'd2 :
                   (count_reg > 5'(PROC_LIMIT)) ? 5'(PROC_LIMIT) : count_reg;

    // The shared unit yields the rotating leader (round mod n) or, for the
    // phase-king protocol, the king of the next phase (next phase mod n).
    assign mod_start = s_tvalid && s_tready;
    assign mod_dvd   = (cfg_reg.protocol_mode == M_KING) ?
                       ((st_reg.phase_number == 8'hFF) ? 8'hFF :
                        st_reg.phase_number + 8'd1) :
                       st_reg.round_number;

    cps_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cps_step u_step (
        .cfg        (cfg_reg),
        .n_eff      (n_eff),
        .st         (st_reg),
        .func       (in_reg[2:0]),
        .msg_value  (in_reg[4:3]),
        .msg_round  (in_reg[12:5]),
        .msg_sender (in_reg[16:13]),
        .mod_rem    (mod_rem),
        .nxt        (st_calc),
        .plan       (plan_calc)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign slot_free = !mv_reg || m_tready;
    // Current broadcast slot is the final recipient of this broadcast.
    assign bc_end = (idx_reg == n_eff - 5'd1) ||
                    (idx_reg == n_eff - 5'd2 && {1'b0, cfg_reg.own_id} == n_eff - 5'd1);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        plan_next  = plan_reg;
        in_next    = in_reg;
        idx_next   = idx_reg;
        bsel_next  = bsel_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_next    = s_tdata;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    st_next    = st_calc;
                    plan_next  = plan_calc;
                    idx_next   = '0;
                    bsel_next  = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (plan_reg.nb == 2'd0)
                begin
                    if (slot_free)
                    begin
                        mv_next = 1'b1;
                        ml_next = 1'b1;
                        if (plan_reg.single)
                            md_next = {plan_reg.dval & {2{plan_reg.dnow}}, plan_reg.dnow,
                                       plan_reg.rnd, plan_reg.value, plan_reg.kind1,
                                       plan_reg.sdest, 1'b1};
                        else
                            md_next = {plan_reg.dval & {2{plan_reg.dnow}}, plan_reg.dnow,
                                       18'd0};
                        state_next = S_IDLE;
                    end
                end
                else if (idx_reg == {1'b0, cfg_reg.own_id})
                begin
                    idx_next = idx_reg + 5'd1;
                end
                else if (slot_free)
                begin
                    mv_next = 1'b1;
                    md_next = {plan_reg.dval & {2{plan_reg.dnow}}, plan_reg.dnow,
                               plan_reg.rnd, plan_reg.value,
                               bsel_reg ? plan_reg.kind2 : plan_reg.kind1,
                               idx_reg[3:0], 1'b1};
                    ml_next  = bc_end && (plan_reg.nb == 2'd1 || bsel_reg);
                    idx_next = idx_reg + 5'd1;
                    if (bc_end)
                    begin
                        if (plan_reg.nb == 2'd2 && !bsel_reg)
                        begin
                            bsel_next = 1'b1;
                            idx_next  = '0;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= '{protocol_mode: M_FLOOD, fault_bound: 4'd1, own_id: 4'd0,
                           own_input: 1'b0, is_correct: 1'b1};
            count_reg <= 5'd4;
            st_reg    <= '0;
            mv_reg    <= 1'b0;
            idx_reg   <= '0;
            bsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            count_reg <= count_next;
            st_reg    <= st_next;
            mv_reg    <= mv_next;
            idx_reg   <= idx_next;
            bsel_reg  <= bsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        in_reg   <= in_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, md_reg};
    assign m_tlast  = ml_reg;

    // An accepted item always goes to the remainder unit next.
    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_DIV)
        else $error("accepted item did not start the remainder unit");

    // The remainder is always below the process count.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> mod_rem < n_eff)
        else $error("remainder not below process count");

    // The broadcast index never runs past the process count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> idx_reg < n_eff)
        else $error("broadcast index out of range");

    // Back in idle, any result still waiting closes its run.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && m_tvalid |-> m_tlast)
        else $error("run left open while idle");

endmodule
